// ===== rtl/sitoa_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sitoa_pkg
// Shared constants and controller/datapath signal groups for the signed
// integer to decimal ASCII unit.
// ----------------------------------------------------------------------------
package sitoa_pkg;

  localparam int unsigned ValueW    = 32;
  localparam int unsigned CharW     = 8;
  localparam int unsigned NumDigits = 10;
  localparam int unsigned DigitW    = 4;
  localparam int unsigned BcdW      = NumDigits * DigitW;
  localparam int unsigned IdxW      = $clog2(NumDigits);
  localparam int unsigned BitCntW   = $clog2(ValueW);

  localparam logic [CharW-1:0]  CharZero  = 8'h30;
  localparam logic [CharW-1:0]  CharMinus = 8'h2D;
  localparam logic [DigitW-1:0] BcdAdjMin = 4'd5;
  localparam logic [DigitW-1:0] BcdAdjAdd = 4'd3;

  // commands from the controller to the datapath
  typedef struct packed {
    logic            load;
    logic            shift;
    logic            char_load;
    logic            sel_sign;
    logic            last;
    logic [IdxW-1:0] idx;
  } cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic            neg;
    logic [IdxW-1:0] top_idx;
  } status_t;

endpackage : sitoa_pkg
`default_nettype wire

// ===== rtl/sitoa_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sitoa_in_if / sitoa_out_if
// Valid/ready channels for integer requests and character results.
// ----------------------------------------------------------------------------
interface sitoa_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface : sitoa_in_if

interface sitoa_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] character;
  logic       last;

  modport source (output valid, output character, output last, input ready);
  modport sink   (input valid, input character, input last, output ready);
endinterface : sitoa_out_if
`default_nettype wire

// ===== rtl/signed_int_to_decimal_ascii_unit.sv =====
`default_nettype none
// Flow: a request is taken in idle, converted by the 32-step bit-serial binary
// to BCD converter, then sent as n = 1..11 characters, one character per cycle
// from the output register while the sink is ready; a new request is taken
// only after the last character has been loaded into the output register.
// Reset: asynchronous active-low reset returns the sequencer to idle and
// drops the output valid; payload registers are not reset.
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_unit
// Converts a 32-bit two's complement integer into its decimal ASCII text,
// sign first, most significant digit first, with a last flag on the end.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii_unit (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  sitoa_in_if.sink  in_i,
  sitoa_out_if.source out_o
);
  import sitoa_pkg::*;

  cmd_t    cmd;
  status_t status;

  sitoa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  sitoa_datapath u_datapath (
    .clk_i    (clk_i),
    .value_i  (in_i.value),
    .cmd_i    (cmd),
    .status_o (status),
    .char_o   (out_o.character),
    .last_o   (out_o.last)
  );

endmodule : signed_int_to_decimal_ascii_unit
`default_nettype wire

// ===== rtl/sitoa_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sitoa_datapath
// Magnitude register, shift-and-add-3 binary to BCD converter and the
// character output register.
// ----------------------------------------------------------------------------
module sitoa_datapath (
  input  wire logic                         clk_i,
  input  wire logic [sitoa_pkg::ValueW-1:0] value_i,
  input  wire sitoa_pkg::cmd_t              cmd_i,
  output sitoa_pkg::status_t                status_o,
  output logic [sitoa_pkg::CharW-1:0]       char_o,
  output logic                              last_o
);
  import sitoa_pkg::*;

  logic [ValueW-1:0] mag_q, mag_d;
  logic [BcdW-1:0]   bcd_q, bcd_d;
  logic              neg_q, neg_d;
  logic [CharW-1:0]  char_q, char_d;
  logic              last_q, last_d;

  logic [DigitW-1:0] digit   [NumDigits];
  logic [BcdW-1:0]   bcd_adj;
  logic [IdxW-1:0]   top_idx;
  logic [DigitW-1:0] sel_digit;

  // split the bcd register into digits and apply add-3 correction
  always_comb begin
    for (int i = 0; i < NumDigits; i++) begin
      digit[i] = bcd_q[i*DigitW +: DigitW];
      if (digit[i] >= BcdAdjMin) begin
        bcd_adj[i*DigitW +: DigitW] = digit[i] + BcdAdjAdd;
      end else begin
        bcd_adj[i*DigitW +: DigitW] = digit[i];
      end
    end
  end

  // highest nonzero digit, zero when all digits are zero
  always_comb begin
    top_idx = '0;
    for (int i = 0; i < NumDigits; i++) begin
      if (digit[i] != '0) begin
        top_idx = IdxW'(i);
      end
    end
  end

  // digit picked for output
  always_comb begin
    if (cmd_i.idx < IdxW'(NumDigits)) begin
      sel_digit = digit[cmd_i.idx];
    end else begin
      sel_digit = '0;
    end
  end

  // next-state logic for magnitude, bcd and character registers
  always_comb begin
    mag_d  = mag_q;
    bcd_d  = bcd_q;
    neg_d  = neg_q;
    char_d = char_q;
    last_d = last_q;
    if (cmd_i.load) begin
      neg_d = value_i[ValueW-1];
      mag_d = value_i[ValueW-1] ? (ValueW'(0) - value_i) : value_i;
      bcd_d = '0;
    end else if (cmd_i.shift) begin
      bcd_d = {bcd_adj[BcdW-2:0], mag_q[ValueW-1]};
      mag_d = {mag_q[ValueW-2:0], 1'b0};
    end
    if (cmd_i.char_load) begin
      char_d = cmd_i.sel_sign ? CharMinus : (CharZero + {{(CharW-DigitW){1'b0}}, sel_digit});
      last_d = cmd_i.last;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk_i) begin
    mag_q  <= mag_d;
    bcd_q  <= bcd_d;
    neg_q  <= neg_d;
    char_q <= char_d;
    last_q <= last_d;
  end

  assign status_o.neg     = neg_q;
  assign status_o.top_idx = top_idx;
  assign char_o           = char_q;
  assign last_o           = last_q;

endmodule : sitoa_datapath
`default_nettype wire

// ===== rtl/sitoa_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sitoa_ctrl
// Sequencer: takes a request, runs the bit-serial conversion, then emits the
// sign and the digits through the output register.
// ----------------------------------------------------------------------------
module sitoa_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  input  wire sitoa_pkg::status_t status_i,
  output sitoa_pkg::cmd_t     cmd_o
);
  import sitoa_pkg::*;

  typedef enum logic [1:0] {
    StIdle,
    StConv,
    StScan,
    StEmit
  } state_e;

  state_e             state_q, state_d;
  logic [BitCntW-1:0] cnt_q, cnt_d;
  logic [IdxW-1:0]    idx_q, idx_d;
  logic               sign_q, sign_d;
  logic               out_valid_q, out_valid_d;
  logic               slot_free;

  assign slot_free = !out_valid_q || out_ready_i;

  // command decode and next state
  always_comb begin
    state_d       = state_q;
    cnt_d         = cnt_q;
    idx_d         = idx_q;
    sign_d        = sign_q;
    out_valid_d   = out_valid_q && !out_ready_i;
    cmd_o         = '0;
    cmd_o.idx     = idx_q;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          cnt_d      = '0;
          state_d    = StConv;
        end
      end
      StConv: begin
        cmd_o.shift = 1'b1;
        cnt_d       = cnt_q + 1'b1;
        if (cnt_q == BitCntW'(ValueW - 1)) begin
          state_d = StScan;
        end
      end
      StScan: begin
        idx_d   = status_i.top_idx;
        sign_d  = status_i.neg;
        state_d = StEmit;
      end
      StEmit: begin
        if (slot_free) begin
          cmd_o.char_load = 1'b1;
          out_valid_d     = 1'b1;
          if (sign_q) begin
            cmd_o.sel_sign = 1'b1;
            sign_d         = 1'b0;
          end else begin
            cmd_o.last = (idx_q == '0);
            idx_d      = idx_q - 1'b1;
            if (idx_q == '0) begin
              state_d = StIdle;
            end
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cnt_q       <= '0;
      idx_q       <= '0;
      sign_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      idx_q       <= idx_d;
      sign_q      <= sign_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = out_valid_q;

endmodule : sitoa_ctrl
`default_nettype wire
